@@ rtl/lpfh_pkg.sv @@
`default_nettype none

package lpfh_pkg;

    // Fixed field widths of the payload
    localparam int COORD_WIDTH     = 24;
    localparam int RATIO_FRAC_BITS = 16;

    // Derived datapath widths
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int MOP_W   = (DIFF_W > RATIO_FRAC_BITS + 2) ? DIFF_W : RATIO_FRAC_BITS + 2;
    localparam int PROD_W  = 2 * MOP_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int KVAL_W  = RATIO_FRAC_BITS + DIFF_W + 2;
    localparam int RATIO_W = RATIO_FRAC_BITS + 1;
    localparam int DIV_CNT_W = $clog2(RATIO_FRAC_BITS + 1);

    // 0.005 in Q.16 for the cross product, 0.005 in Q.8 for an edge delta
    localparam int DEN_NEAR_ZERO  = 327;
    localparam int EDGE_NEAR_ZERO = 1;
    localparam int RATIO_HALF     = 1 << (RATIO_FRAC_BITS - 1);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]      t_diff;
    typedef logic signed [MOP_W-1:0]       t_mop;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [ACC_W-1:0]       t_acc;
    typedef logic signed [KVAL_W-1:0]      t_kval;
    typedef logic [RATIO_W-1:0]            t_ratio;
    typedef logic [RATIO_FRAC_BITS-1:0]    t_quot;

    localparam t_ratio RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_BITS;

    typedef struct packed {
        t_coord line_start_x;
        t_coord line_start_y;
        t_coord line_end_x;
        t_coord line_end_y;
        t_coord vertex_x;
        t_coord vertex_y;
        logic   first_vertex;
        logic   last_vertex;
    } t_in;

    typedef struct packed {
        t_coord end_x;
        t_coord end_y;
        t_ratio hit_ratio;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_NORM,
        ST_CHK,
        ST_DIV,
        ST_KMUL,
        ST_KSUM,
        ST_KNORM,
        ST_KCHK,
        ST_PMUL,
        ST_PSUM,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        MS_EYDX,
        MS_DYEX,
        MS_RXEY,
        MS_EXRY,
        MS_LAST
    } t_mstep;

endpackage

`default_nettype wire

@@ rtl/lpfh_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle; needs 0 < num < den.
module lpfh_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  lpfh_pkg::t_acc i_num,
    input  lpfh_pkg::t_acc i_den,
    output logic           o_done,
    output lpfh_pkg::t_quot o_quot
);
    import lpfh_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0]     r_rem;
    logic [ACC_W-1:0]     r_den;
    t_quot                r_q;
    logic [ACC_W-1:0]     w_sh;
    logic                 w_ge;

    assign w_sh   = {r_rem[ACC_W-2:0], 1'b0};
    assign w_ge   = (w_sh >= r_den);
    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(RATIO_FRAC_BITS);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= $unsigned(i_num);
            r_den <= $unsigned(i_den);
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= w_ge ? (w_sh - r_den) : w_sh;
            r_q   <= {r_q[RATIO_FRAC_BITS-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

@@ rtl/line_polyline_first_hit.sv @@
`default_nettype none

// Nearest crossing of a line with a closed polyline.
// Input channel (i_in_valid / o_in_ready / i_in_data): one polyline vertex per
// transaction. The vertex flagged first also carries the line end points and
// opens a new polyline. Output channel (o_out_valid / i_out_ready / o_out_data):
// one transaction per vertex flagged last, giving the nearest hit point and its
// fraction along the line in Q1.16 (one, with the line end, when nothing hit).
// Flow: a first vertex alone only loads the line and the vertex. Every other
// vertex tests one edge, the last vertex also the closing edge unless it already
// closes the polyline. An edge is rejected early when parallel or out of range,
// else it goes through the divider, which produces one quotient bit per cycle
// and sets the pace; one shared multiplier serves all products. A last vertex
// then places the result point on both axes before it is offered on the output.
// o_in_ready is high only while the sequencer is idle; one vertex is in work at
// a time. The result sits in an output register, so the next vertex is taken
// while it waits; if the receiver stalls, a following result is held back
// until the register is free. Synchronous reset clears the held line, vertices
// and best fraction to the power-on values and drops any pending result.
module line_polyline_first_hit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lpfh_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output lpfh_pkg::t_out o_out_data
);
    import lpfh_pkg::*;

    // sequencer
    t_state r_state, n_state;
    t_mstep r_mstep;
    logic   r_closing;   // working on the closing edge
    logic   r_side;      // placing y (else x)

    // held polyline state
    t_coord r_sx, r_sy, r_lex, r_ley;
    t_coord r_first_vx, r_first_vy, r_prev_vx, r_prev_vy;
    t_ratio r_best;

    // current vertex transaction
    t_coord r_vx, r_vy;
    logic   r_last;

    // edge datapath
    t_diff  r_dx, r_dy, r_ex, r_ey, r_rx, r_ry, r_kd;
    t_prod  r_prod;
    t_acc   r_den, r_num;
    t_quot  r_t;
    t_kval  r_kn;
    t_coord r_px, r_py;

    // output register
    logic   r_out_valid;
    t_out   r_out;

    logic   w_acc;
    t_coord w_ax, w_ay, w_bx, w_by;
    t_diff  w_ldx, w_ldy;
    t_mop   w_ma, w_mb;
    t_prod  w_prod;
    logic   w_use_x;
    logic   w_can_hit;
    logic   w_k_hit;
    logic   w_edge_end;
    logic   w_need_close;
    logic   w_out_free;
    logic   w_div_start;
    logic   w_div_done;
    t_quot  w_div_quot;
    t_kval  w_pv;
    t_coord w_place;

    assign w_acc       = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // edge end points: previous -> current, or current -> first when closing
    assign w_ax = r_closing ? r_vx : r_prev_vx;
    assign w_ay = r_closing ? r_vy : r_prev_vy;
    assign w_bx = r_closing ? r_first_vx : r_vx;
    assign w_by = r_closing ? r_first_vy : r_vy;

    assign w_ldx = t_diff'(r_lex) - t_diff'(r_sx);
    assign w_ldy = t_diff'(r_ley) - t_diff'(r_sy);

    // nearly horizontal edge: solve k along x
    assign w_use_x = (r_ey >= -t_diff'(EDGE_NEAR_ZERO)) && (r_ey <= t_diff'(EDGE_NEAR_ZERO));

    // after sign folding: not parallel and 0 < num < den
    assign w_can_hit = (r_den > t_acc'(DEN_NEAR_ZERO)) && (r_num > t_acc'(0))
                       && (r_num < r_den);

    // 0 <= k < 1 without dividing; zero divisor is a miss
    assign w_k_hit = (r_kd != t_diff'(0)) && (r_kn >= t_kval'(0))
                     && (r_kn < (t_kval'(r_kd) <<< RATIO_FRAC_BITS));

    assign w_edge_end   = ((r_state == ST_CHK) && !w_can_hit) || (r_state == ST_KCHK);
    assign w_need_close = !r_closing && r_last
                          && !((r_vx == r_first_vx) && (r_vy == r_first_vy));
    assign w_div_start  = (r_state == ST_CHK) && w_can_hit;

    // result point: start + round(d * best / 2^F), halves up
    assign w_pv    = t_kval'(r_prod) + t_kval'(RATIO_HALF);
    assign w_place = t_coord'(t_kval'(r_side ? r_sy : r_sx) + (w_pv >>> RATIO_FRAC_BITS));

    // shared multiplier, product registered in r_prod
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            ST_MUL: begin
                case (r_mstep)
                    MS_EYDX: begin
                        w_ma = t_mop'(r_ey);
                        w_mb = t_mop'(r_dx);
                    end
                    MS_DYEX: begin
                        w_ma = t_mop'(r_dy);
                        w_mb = t_mop'(r_ex);
                    end
                    MS_RXEY: begin
                        w_ma = t_mop'(r_rx);
                        w_mb = t_mop'(r_ey);
                    end
                    MS_EXRY: begin
                        w_ma = t_mop'(r_ex);
                        w_mb = t_mop'(r_ry);
                    end
                    default: ;
                endcase
            end
            ST_KMUL: begin
                w_ma = t_mop'($signed({1'b0, r_t}));
                w_mb = w_use_x ? t_mop'(r_dx) : t_mop'(r_dy);
            end
            ST_PMUL: begin
                w_ma = t_mop'($signed({1'b0, r_best}));
                w_mb = r_side ? t_mop'(w_ldy) : t_mop'(w_ldx);
            end
            default: ;
        endcase
    end

    assign w_prod = w_ma * w_mb;

    lpfh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (!i_in_data.first_vertex) begin
                        n_state = ST_LOAD;
                    end else if (i_in_data.last_vertex) begin
                        n_state = ST_PMUL;
                    end
                end
            end
            ST_LOAD:  n_state = ST_MUL;
            ST_MUL: begin
                if (r_mstep == MS_LAST) begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM:  n_state = ST_CHK;
            ST_CHK: begin
                if (w_can_hit) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_KMUL;
                end
            end
            ST_KMUL:  n_state = ST_KSUM;
            ST_KSUM:  n_state = ST_KNORM;
            ST_KNORM: n_state = ST_KCHK;
            ST_KCHK:  n_state = ST_KCHK;
            ST_PMUL:  n_state = ST_PSUM;
            ST_PSUM:  n_state = r_side ? ST_OUT : ST_PMUL;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
        if (w_edge_end) begin
            if (w_need_close) begin
                n_state = ST_LOAD;
            end else begin
                n_state = r_last ? ST_PMUL : ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mstep     <= MS_EYDX;
            r_closing   <= 1'b0;
            r_side      <= 1'b0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_lex       <= '0;
            r_ley       <= '0;
            r_first_vx  <= '0;
            r_first_vy  <= '0;
            r_prev_vx   <= '0;
            r_prev_vy   <= '0;
            r_best      <= RATIO_ONE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_closing <= 1'b0;
                    r_side    <= 1'b0;
                    if (w_acc && i_in_data.first_vertex) begin
                        r_sx       <= i_in_data.line_start_x;
                        r_sy       <= i_in_data.line_start_y;
                        r_lex      <= i_in_data.line_end_x;
                        r_ley      <= i_in_data.line_end_y;
                        r_first_vx <= i_in_data.vertex_x;
                        r_first_vy <= i_in_data.vertex_y;
                        r_prev_vx  <= i_in_data.vertex_x;
                        r_prev_vy  <= i_in_data.vertex_y;
                        r_best     <= RATIO_ONE;
                    end
                end
                ST_LOAD: r_mstep <= MS_EYDX;
                ST_MUL: begin
                    unique case (r_mstep)
                        MS_EYDX: r_mstep <= MS_DYEX;
                        MS_DYEX: r_mstep <= MS_RXEY;
                        MS_RXEY: r_mstep <= MS_EXRY;
                        MS_EXRY: r_mstep <= MS_LAST;
                        MS_LAST: r_mstep <= MS_LAST;
                        default: r_mstep <= MS_EYDX;
                    endcase
                end
                ST_KCHK: begin
                    if (w_k_hit && (t_ratio'(r_t) < r_best)) begin
                        r_best <= t_ratio'(r_t);
                    end
                end
                ST_PSUM: r_side <= 1'b1;
                ST_OUT: begin
                    if (w_out_free) begin
                        r_best <= RATIO_ONE;
                    end
                end
                default: ;
            endcase
            if (w_edge_end) begin
                if (w_need_close) begin
                    r_closing <= 1'b1;
                end else begin
                    r_prev_vx <= r_vx;
                    r_prev_vy <= r_vy;
                end
            end
            // result register: loaded by the sequencer, emptied by the receiver
            if ((r_state == ST_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // edge datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    r_vx   <= i_in_data.vertex_x;
                    r_vy   <= i_in_data.vertex_y;
                    r_last <= i_in_data.last_vertex;
                end
            end
            ST_LOAD: begin
                r_ex <= t_diff'(w_bx) - t_diff'(w_ax);
                r_ey <= t_diff'(w_by) - t_diff'(w_ay);
                r_rx <= t_diff'(w_ax) - t_diff'(r_sx);
                r_ry <= t_diff'(w_ay) - t_diff'(r_sy);
                r_dx <= w_ldx;
                r_dy <= w_ldy;
            end
            ST_MUL: begin
                // den = ey*dx - dy*ex, num = rx*ey - ex*ry, one product behind
                if (r_mstep != MS_LAST) begin
                    r_prod <= w_prod;
                end
                case (r_mstep)
                    MS_DYEX: r_den <= t_acc'(r_prod);
                    MS_RXEY: r_den <= r_den - t_acc'(r_prod);
                    MS_EXRY: r_num <= t_acc'(r_prod);
                    MS_LAST: r_num <= r_num - t_acc'(r_prod);
                    default: ;
                endcase
            end
            ST_NORM: begin
                if (r_den < t_acc'(0)) begin
                    r_den <= -r_den;
                    r_num <= -r_num;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    r_t <= w_div_quot;
                end
            end
            ST_KMUL: begin
                r_prod <= w_prod;
                r_kd   <= w_use_x ? r_ex : r_ey;
                r_kn   <= -(t_kval'(w_use_x ? r_rx : r_ry) <<< RATIO_FRAC_BITS);
            end
            ST_KSUM: r_kn <= r_kn + t_kval'(r_prod);
            ST_KNORM: begin
                if (r_kd < t_diff'(0)) begin
                    r_kd <= -r_kd;
                    r_kn <= -r_kn;
                end
            end
            ST_PMUL: r_prod <= w_prod;
            ST_PSUM: begin
                if (r_side) begin
                    r_py <= w_place;
                end else begin
                    r_px <= w_place;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    r_out.end_x     <= r_px;
                    r_out.end_y     <= r_py;
                    r_out.hit_ratio <= r_best;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/lpfh_chk.sv @@
`default_nettype none

module lpfh_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input lpfh_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input lpfh_pkg::t_out o_out_data
);
    import lpfh_pkg::*;

    // a vertex that opens an edge keeps the sequencer busy
    a_busy_after_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_in_data.first_vertex) |=> !o_in_ready)
        else $error("ready held high after a vertex with an edge");

    // only a last vertex may raise a result
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_in_data.last_vertex && !o_out_valid)
        |=> !o_out_valid)
        else $error("result raised by a vertex not marked last");

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.hit_ratio <= RATIO_ONE))
        else $error("hit ratio above one");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result dropped or changed");

endmodule

bind line_polyline_first_hit lpfh_chk u_lpfh_chk (.*);

`default_nettype wire

@@ tb/sv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lpfh_pkg::*;

    // Coordinate extremes and a Q1.16 one held as a 64-bit value for the arithmetic below
    localparam int     COORD_MAX   = (1 << (COORD_WIDTH - 1)) - 1;
    localparam int     COORD_MIN   = -COORD_MAX - 1;
    localparam longint ONE_Q       = longint'(1) << RATIO_FRAC_BITS;
    localparam int     RANDOM_ITEMS = 1250;
    localparam int     CALM_TAIL   = 150;       // last transactions sent with no idling
    localparam int     HOLD_AT     = 300;       // long receiver hold-off starts here
    localparam int     HOLD_LEN    = 500;
    localparam int     DRAIN_CYCLES = 80;       // > worst vertex latency
    localparam int     CYCLE_LIMIT = 600000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    logic   o_in_ready;
    t_in    i_in_data = '0;
    logic   o_out_valid;
    logic   i_out_ready = 1'b0;
    t_out   o_out_data;

    line_polyline_first_hit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Hit predictor: own copy of the polyline state, updated for every
    // vertex transaction the block accepts.
    // ------------------------------------------------------------------
    longint ln_sx = 0, ln_sy = 0, ln_ex = 0, ln_ey = 0;   // held line
    longint fv_x = 0, fv_y = 0;                           // first vertex
    longint pv_x = 0, pv_y = 0;                           // previous vertex
    t_ratio best_t = RATIO_ONE;

    t_in    pending[$];     // vertices still to be offered
    t_out   hits_due[$];    // results owed by the block, oldest first

    int     sent_cnt = 0;
    int     total_items = 0;
    int     err_cnt = 0;
    int     hold_cycles = 0;
    bit     hold_done = 1'b0;
    int     cycle_cnt = 0;

    // Fraction along the line at which edge a->b is crossed, one on a miss
    function automatic t_ratio edge_fraction(longint ax, longint ay, longint bx, longint by);
        longint      dx, dy, ex, ey, den, num, kn, kd;
        logic [127:0] scaled;
        t_ratio      t;
        dx  = ln_ex - ln_sx;
        dy  = ln_ey - ln_sy;
        ex  = bx - ax;
        ey  = by - ay;
        den = ey * dx - dy * ex;
        num = (ax - ln_sx) * ey + ex * (ln_sy - ay);
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        // near-parallel, or crossing outside the open interval 0 < t < 1
        if (den <= DEN_NEAR_ZERO)
            return RATIO_ONE;
        if (num <= 0 || num >= den)
            return RATIO_ONE;
        scaled = 128'(num) << RATIO_FRAC_BITS;
        t = t_ratio'(scaled / 128'(den));
        // edge parameter from the quantised t; a flat edge is measured along x
        if (ey <= EDGE_NEAR_ZERO && ey >= -EDGE_NEAR_ZERO) begin
            kd = ex;
            kn = (ln_sx - ax) * ONE_Q + longint'(t) * dx;
        end else begin
            kd = ey;
            kn = (ln_sy - ay) * ONE_Q + longint'(t) * dy;
        end
        if (kd == 0)
            return RATIO_ONE;   // degenerate edge: no crossing
        if (kd < 0) begin
            kd = -kd;
            kn = -kn;
        end
        if (kn >= 0 && kn < kd * ONE_Q)
            return t;
        return RATIO_ONE;
    endfunction

    // start + round(delta * t), halves upwards
    function automatic t_coord place_axis(longint s, longint e);
        longint v;
        v = (e - s) * longint'(best_t) + RATIO_HALF;
        return t_coord'(s + (v >>> RATIO_FRAC_BITS));
    endfunction

    function automatic void trace_vertex(t_in v);
        longint vx, vy;
        t_ratio t;
        t_out   res;
        vx = longint'($signed(v.vertex_x));
        vy = longint'($signed(v.vertex_y));
        if (v.first_vertex) begin
            ln_sx  = longint'($signed(v.line_start_x));
            ln_sy  = longint'($signed(v.line_start_y));
            ln_ex  = longint'($signed(v.line_end_x));
            ln_ey  = longint'($signed(v.line_end_y));
            fv_x   = vx;
            fv_y   = vy;
            best_t = RATIO_ONE;
        end else begin
            t = edge_fraction(pv_x, pv_y, vx, vy);
            if (t < best_t)
                best_t = t;
            // closing edge, skipped when the polyline is already closed
            if (v.last_vertex && !(vx == fv_x && vy == fv_y)) begin
                t = edge_fraction(vx, vy, fv_x, fv_y);
                if (t < best_t)
                    best_t = t;
            end
        end
        pv_x = vx;
        pv_y = vy;
        if (v.last_vertex) begin
            res.end_x     = place_axis(ln_sx, ln_ex);
            res.end_y     = place_axis(ln_sy, ln_ey);
            res.hit_ratio = best_t;
            hits_due.push_back(res);
            best_t = RATIO_ONE;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    function automatic t_in mk_vertex(int sx, int sy, int ex, int ey, int vx, int vy,
                                      bit f, bit l);
        t_in v;
        v.line_start_x = t_coord'(sx);
        v.line_start_y = t_coord'(sy);
        v.line_end_x   = t_coord'(ex);
        v.line_end_y   = t_coord'(ey);
        v.vertex_x     = t_coord'(vx);
        v.vertex_y     = t_coord'(vy);
        v.first_vertex = f;
        v.last_vertex  = l;
        return v;
    endfunction

    // span 0 means the full coordinate range
    function automatic t_coord pick_coord(int span);
        if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 4))
                0:       return t_coord'(COORD_MIN);
                1:       return t_coord'(COORD_MAX);
                2:       return t_coord'(0);
                3:       return t_coord'(-1);
                default: return t_coord'(1);
            endcase
        end
        if (span == 0)
            return t_coord'($urandom);
        return t_coord'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic t_in noise_vertex();
        t_in v;
        v = t_in'({$urandom, $urandom, $urandom, $urandom, $urandom});
        return v;
    endfunction

    // One polyline: a first vertex carrying the line, then up to seven more
    function automatic int queue_polyline();
        t_in    v;
        int     span, n;
        t_coord fx, fy;
        case ($urandom_range(0, 9))
            7, 8:    span = 262144;
            9:       span = 0;
            default: span = 4096;
        endcase
        n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 7);
        v.line_start_x = pick_coord(span);
        v.line_start_y = pick_coord(span);
        v.line_end_x   = pick_coord(span);
        v.line_end_y   = pick_coord(span);
        v.vertex_x     = pick_coord(span);
        v.vertex_y     = pick_coord(span);
        v.first_vertex = 1'b1;
        v.last_vertex  = (n == 0);
        fx = v.vertex_x;
        fy = v.vertex_y;
        pending.push_back(v);
        for (int i = 1; i <= n; i++) begin
            // line fields are don't-care here; full-range noise on them
            v = noise_vertex();
            v.vertex_x     = pick_coord(span);
            v.vertex_y     = pick_coord(span);
            v.first_vertex = 1'b0;
            v.last_vertex  = (i == n);
            if (i == n && $urandom_range(0, 9) == 0) begin
                v.vertex_x = fx;    // already closed
                v.vertex_y = fy;
            end
            if (i == n && $urandom_range(0, 19) == 0)
                v.last_vertex = 1'b0;   // unterminated polyline
            pending.push_back(v);
        end
        return n + 1;
    endfunction

    function automatic bit idling_allowed();
        return (sent_cnt + CALM_TAIL < total_items) && ((sent_cnt / 100) % 4 != 3);
    endfunction

    task automatic note_failure(string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued vertices, random gaps between transactions
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : vertex_driver
        int gap_left;
        bit take;
        if (i_rst_n) begin
            take = i_in_valid && o_in_ready;
            if (take) begin
                trace_vertex(i_in_data);
                sent_cnt <= sent_cnt + 1;
            end
            if (!i_in_valid || take) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (idling_allowed() && $urandom_range(0, 4) == 0) begin
                    gap_left = $urandom_range(0, 14);
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending.pop_front();
                end
            end
        end else begin
            gap_left = 0;
        end
    end

    // Long receiver hold-off, once, so the output register fills and
    // the block pushes back on its input
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_cycles != 0)
                hold_cycles <= hold_cycles - 1;
            else if (!hold_done && sent_cnt >= HOLD_AT) begin
                hold_cycles <= HOLD_LEN;
                hold_done   <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transaction against the oldest
    // prediction and drives the receiver's ready with random stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        int   stall_left;
        t_out want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (hits_due.size() == 0) begin
                    note_failure($sformatf("unexpected result x=%0d y=%0d ratio=%0d",
                        $signed(o_out_data.end_x), $signed(o_out_data.end_y),
                        o_out_data.hit_ratio));
                end else begin
                    want = hits_due.pop_front();
                    if (o_out_data.end_x !== want.end_x || o_out_data.end_y !== want.end_y
                            || o_out_data.hit_ratio !== want.hit_ratio)
                        note_failure($sformatf(
                            "result mismatch: exp x=%0d y=%0d ratio=%0d, got x=%0d y=%0d ratio=%0d",
                            $signed(want.end_x), $signed(want.end_y), want.hit_ratio,
                            $signed(o_out_data.end_x), $signed(o_out_data.end_y),
                            o_out_data.hit_ratio));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (hold_cycles != 0) begin
                i_out_ready <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 14);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end else begin
            stall_left = 0;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed polylines, random polylines, then drain
    // ------------------------------------------------------------------
    initial begin : run_sequence
        int made;
        // vertices before any first vertex: edges run from the reset state
        pending.push_back(mk_vertex(77, 88, 99, 11, 1000, -500, 1'b0, 1'b0));
        pending.push_back(mk_vertex(0, 0, 0, 0, -200, 300, 1'b0, 1'b1));
        // first and last on one transaction: no edge, line end returned
        pending.push_back(mk_vertex(100, 200, 5000, -3000, 42, 43, 1'b1, 1'b1));
        // square across the line: far side at t=0.4, closing edge at t=0.2 wins
        pending.push_back(mk_vertex(0, 0, 25600, 0, 5120, -2560, 1'b1, 1'b0));
        pending.push_back(mk_vertex(0, 0, 0, 0, 10240, -2560, 1'b0, 1'b0));
        pending.push_back(mk_vertex(0, 0, 0, 0, 10240, 2560, 1'b0, 1'b0));
        pending.push_back(mk_vertex(0, 0, 0, 0, 5120, 2560, 1'b0, 1'b1));
        // triangle already closed: closing edge skipped
        pending.push_back(mk_vertex(0, 0, 25600, 0, 1000, -1000, 1'b1, 1'b0));
        pending.push_back(mk_vertex(0, 0, 0, 0, 3000, 1000, 1'b0, 1'b0));
        pending.push_back(mk_vertex(0, 0, 0, 0, 1000, -1000, 1'b0, 1'b1));
        // almost flat edge (dy of one LSB): edge parameter taken along x
        pending.push_back(mk_vertex(0, -10000, 0, 10000, -500, 0, 1'b1, 1'b0));
        pending.push_back(mk_vertex(0, 0, 0, 0, 500, 1, 1'b0, 1'b1));
        // flat-test edge with zero x extent: zero divisor, counted as a miss
        pending.push_back(mk_vertex(0, 0, 1000, 0, 500, 0, 1'b1, 0));
        pending.push_back(mk_vertex(0, 0, 0, 0, 500, 1, 1'b0, 1'b1));
        // coordinate extremes
        pending.push_back(mk_vertex(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                                    COORD_MAX, COORD_MIN, 1'b1, 1'b0));
        pending.push_back(mk_vertex(0, 0, 0, 0, COORD_MIN, COORD_MAX, 1'b0, 1'b0));
        pending.push_back(mk_vertex(0, 0, 0, 0, COORD_MIN, COORD_MIN, 1'b0, 1'b0));
        pending.push_back(mk_vertex(0, 0, 0, 0, COORD_MAX, COORD_MAX, 1'b0, 1'b1));
        // crossings exactly at t=0 and t=1 are misses
        pending.push_back(mk_vertex(0, 0, 1000, 0, 0, -100, 1'b1, 1'b0));
        pending.push_back(mk_vertex(0, 0, 0, 0, 0, 100, 1'b0, 1'b0));
        pending.push_back(mk_vertex(0, 0, 0, 0, 1000, 100, 1'b0, 1'b0));
        pending.push_back(mk_vertex(0, 0, 0, 0, 1000, -100, 1'b0, 1'b1));
        // carries on after a result without a new first vertex
        pending.push_back(mk_vertex(0, 0, 0, 0, 500, -300, 1'b0, 1'b1));
        // edge starting on the line: k exactly zero counts as a hit
        pending.push_back(mk_vertex(0, 0, 10000, 0, 3000, 0, 1'b1, 1'b0));
        pending.push_back(mk_vertex(0, 0, 0, 0, 3000, 500, 1'b0, 1'b1));

        made = 0;
        while (made < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                pending.push_back(noise_vertex());
                made++;
            end else begin
                made += queue_polyline();
            end
        end
        total_items = pending.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sampled on the falling edge, away from the driver and monitor
        do
            @(negedge i_clk);
        while (pending.size() != 0 || i_in_valid || hits_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
